@@ rtl/assert_macros.svh @@
// Assertion macros shared by the upwind momentum RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ rtl/upwm_pkg.sv @@
// Types, widths and register codes for the upwind x-momentum pipeline.
package upwm_pkg;

	localparam int VALUE_WIDTH = 32;
	// Working value width, clamped to 16..32 so the 32-bit fields can carry it.
	localparam int VAL_W  = (VALUE_WIDTH > 32) ? 32 : ((VALUE_WIDTH < 16) ? 16 : VALUE_WIDTH);
	localparam int FIELD_W = 32;
	localparam int DENS_W = 31;
	localparam int INV_W  = 32;
	localparam int FRAC   = 16;
	localparam int DIFF_W = VAL_W + 1;
	localparam int PROD_W = DIFF_W + INV_W + 1;
	localparam int MUL_W  = VAL_W + DENS_W + 1;
	localparam int SUM_W  = MUL_W - FRAC + 3;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_INV_DX = 3'd0,
		REG_INV_DY = 3'd1,
		REG_INV_DZ = 3'd2,
		REG_P_EN   = 3'd3,
		REG_A_EN   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [INV_W-1:0] inv_dx;
		logic [INV_W-1:0] inv_dy;
		logic [INV_W-1:0] inv_dz;
		logic             pressure_enable;
		logic             advection_enable;
	} cfg_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] vx_center;
		logic signed [FIELD_W-1:0] vx_x_minus;
		logic signed [FIELD_W-1:0] vx_x_plus;
		logic signed [FIELD_W-1:0] vx_y_minus;
		logic signed [FIELD_W-1:0] vx_y_plus;
		logic signed [FIELD_W-1:0] vx_z_minus;
		logic signed [FIELD_W-1:0] vx_z_plus;
		logic signed [FIELD_W-1:0] vy_center;
		logic signed [FIELD_W-1:0] vz_center;
		logic signed [FIELD_W-1:0] p_x_minus;
		logic signed [FIELD_W-1:0] p_x_plus;
		logic        [DENS_W-1:0]  inv_density;
	} stencil_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] rhs_value;
		logic                      saturated;
	} rhs_t;

	// Stage 1 result: upwind-selected differences plus pass-through operands.
	typedef struct packed {
		logic signed [DIFF_W-1:0] diff_p;
		logic signed [DIFF_W-1:0] diff_x;
		logic signed [DIFF_W-1:0] diff_y;
		logic signed [DIFF_W-1:0] diff_z;
		logic signed [VAL_W-1:0]  vx;
		logic signed [VAL_W-1:0]  vy;
		logic signed [VAL_W-1:0]  vz;
		logic        [DENS_W-1:0] rho;
	} sel_t;

	// Stage 3 result: saturated derivatives and their clip flags.
	typedef struct packed {
		logic signed [VAL_W-1:0]  dp;
		logic signed [VAL_W-1:0]  ddx;
		logic signed [VAL_W-1:0]  ddy;
		logic signed [VAL_W-1:0]  ddz;
		logic                     clip_p;
		logic                     clip_adv;
		logic signed [VAL_W-1:0]  vx;
		logic signed [VAL_W-1:0]  vy;
		logic signed [VAL_W-1:0]  vz;
		logic        [DENS_W-1:0] rho;
	} deriv_t;

endpackage

@@ rtl/upwind_momentum_rhs_x.sv @@
// Top level: first-order upwind x-momentum right-hand side, five-stage pipeline.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+---------------------------------
//  stencil   | stencil_valid/stencil_stall | upwm_pkg::stencil_t, one cell
//  rhs       | rhs_valid/rhs_stall         | upwm_pkg::rhs_t, one result
//  apb       | psel/penable/pwrite/pready  | paddr[4:0], pwdata, prdata
//
//  Five register stages: a stencil transaction accepted at an edge is held in
//  stage 1, then moves through stages 2 to 5, where rhs_valid rises.
//  One transaction per cycle sustained while rhs_stall is low; the two
//  multiplier ranks (stages 2 and 4) set the stage depth.
//  Reset clears all valid bits and loads the registers with 1.0 spacing and both
//  terms enabled.
//  A stall on rhs holds only the occupied stages; bubbles ahead of it still fill,
//  so stencil_stall rises only when every stage is full.
//  Registers: 0 inv_dx, 1 inv_dy, 2 inv_dz, 3 pressure_enable, 4 advection_enable.
module upwind_momentum_rhs_x (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [upwm_pkg::ADDR_W-1:0] paddr,
	input  logic [upwm_pkg::DATA_W-1:0] pwdata,
	output logic [upwm_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	// stencil input
	input  logic                        stencil_valid,
	output logic                        stencil_stall,
	input  upwm_pkg::stencil_t          stencil,
	// result output
	output logic                        rhs_valid,
	input  logic                        rhs_stall,
	output upwm_pkg::rhs_t              rhs
);

	upwm_pkg::cfg_t   cfg;
	upwm_pkg::sel_t   sel;
	upwm_pkg::deriv_t deriv;
	logic             sel_valid, sel_stall;
	logic             deriv_valid, deriv_stall;

	// Register file, read live by the pipeline; write only when idle (not enforced).
	upwm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage 1: sign-based upwind pick and the four differences.
	upwm_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (stencil_valid),
		.up_stall (stencil_stall),
		.up_data  (stencil),
		.dn_valid (sel_valid),
		.dn_stall (sel_stall),
		.dn_data  (sel)
	);

	// Stages 2-3: scale by reciprocal spacing, saturate each derivative.
	upwm_deriv u_deriv (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (sel_valid),
		.up_stall (sel_stall),
		.up_data  (sel),
		.dn_valid (deriv_valid),
		.dn_stall (deriv_stall),
		.dn_data  (deriv)
	);

	// Stages 4-5: advective and pressure products, sum, clip; stage 5 is the
	// output register.
	upwm_combine u_combine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (deriv_valid),
		.up_stall (deriv_stall),
		.up_data  (deriv),
		.dn_valid (rhs_valid),
		.dn_stall (rhs_stall),
		.dn_data  (rhs)
	);

endmodule

@@ rtl/upwm_cfg_regs.sv @@
// APB register file: grid spacing reciprocals and term enables.
module upwm_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [upwm_pkg::ADDR_W-1:0] paddr,
	input  logic [upwm_pkg::DATA_W-1:0] pwdata,
	output logic [upwm_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output upwm_pkg::cfg_t              cfg
);

	upwm_pkg::cfg_t    cfg_q;
	upwm_pkg::reg_idx_t idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign idx    = upwm_pkg::reg_idx_t'(paddr[upwm_pkg::ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_dx           <= upwm_pkg::INV_W'(65536);
			cfg_q.inv_dy           <= upwm_pkg::INV_W'(65536);
			cfg_q.inv_dz           <= upwm_pkg::INV_W'(65536);
			cfg_q.pressure_enable  <= 1'b1;
			cfg_q.advection_enable <= 1'b1;
		end else if (wr_en) begin
			case (idx)
				upwm_pkg::REG_INV_DX: cfg_q.inv_dx <= pwdata[upwm_pkg::INV_W-1:0];
				upwm_pkg::REG_INV_DY: cfg_q.inv_dy <= pwdata[upwm_pkg::INV_W-1:0];
				upwm_pkg::REG_INV_DZ: cfg_q.inv_dz <= pwdata[upwm_pkg::INV_W-1:0];
				upwm_pkg::REG_P_EN:   cfg_q.pressure_enable <= pwdata[0];
				upwm_pkg::REG_A_EN:   cfg_q.advection_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			upwm_pkg::REG_INV_DX: prdata = upwm_pkg::DATA_W'(cfg_q.inv_dx);
			upwm_pkg::REG_INV_DY: prdata = upwm_pkg::DATA_W'(cfg_q.inv_dy);
			upwm_pkg::REG_INV_DZ: prdata = upwm_pkg::DATA_W'(cfg_q.inv_dz);
			upwm_pkg::REG_P_EN:   prdata = upwm_pkg::DATA_W'(cfg_q.pressure_enable);
			upwm_pkg::REG_A_EN:   prdata = upwm_pkg::DATA_W'(cfg_q.advection_enable);
			default:              prdata = '0;
		endcase
	end

endmodule

@@ rtl/upwm_select.sv @@
// Stage 1: upwind direction select and stencil differences.
`include "assert_macros.svh"
module upwm_select (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_stall,
	input  upwm_pkg::stencil_t up_data,
	output logic               dn_valid,
	input  logic               dn_stall,
	output upwm_pkg::sel_t     dn_data
);

	logic                              v_s1;
	upwm_pkg::sel_t                    sel_s1;
	upwm_pkg::sel_t                    sel_d;
	logic                              load;
	logic signed [upwm_pkg::VAL_W-1:0] vx, vxm, vxp, vym, vyp, vzm, vzp, vy, vz, pm, pp;

	// Low VAL_W bits of each field, taken as signed.
	assign vx  = $signed(up_data.vx_center[upwm_pkg::VAL_W-1:0]);
	assign vxm = $signed(up_data.vx_x_minus[upwm_pkg::VAL_W-1:0]);
	assign vxp = $signed(up_data.vx_x_plus[upwm_pkg::VAL_W-1:0]);
	assign vym = $signed(up_data.vx_y_minus[upwm_pkg::VAL_W-1:0]);
	assign vyp = $signed(up_data.vx_y_plus[upwm_pkg::VAL_W-1:0]);
	assign vzm = $signed(up_data.vx_z_minus[upwm_pkg::VAL_W-1:0]);
	assign vzp = $signed(up_data.vx_z_plus[upwm_pkg::VAL_W-1:0]);
	assign vy  = $signed(up_data.vy_center[upwm_pkg::VAL_W-1:0]);
	assign vz  = $signed(up_data.vz_center[upwm_pkg::VAL_W-1:0]);
	assign pm  = $signed(up_data.p_x_minus[upwm_pkg::VAL_W-1:0]);
	assign pp  = $signed(up_data.p_x_plus[upwm_pkg::VAL_W-1:0]);

	// Non-negative velocity -> backward difference, else forward.
	always_comb begin
		sel_d.diff_p = upwm_pkg::DIFF_W'(pp) - upwm_pkg::DIFF_W'(pm);
		sel_d.diff_x = vx[upwm_pkg::VAL_W-1] ? (upwm_pkg::DIFF_W'(vxp) - upwm_pkg::DIFF_W'(vx))
		                                     : (upwm_pkg::DIFF_W'(vx) - upwm_pkg::DIFF_W'(vxm));
		sel_d.diff_y = vy[upwm_pkg::VAL_W-1] ? (upwm_pkg::DIFF_W'(vyp) - upwm_pkg::DIFF_W'(vx))
		                                     : (upwm_pkg::DIFF_W'(vx) - upwm_pkg::DIFF_W'(vym));
		sel_d.diff_z = vz[upwm_pkg::VAL_W-1] ? (upwm_pkg::DIFF_W'(vzp) - upwm_pkg::DIFF_W'(vx))
		                                     : (upwm_pkg::DIFF_W'(vx) - upwm_pkg::DIFF_W'(vzm));
		sel_d.vx  = vx;
		sel_d.vy  = vy;
		sel_d.vz  = vz;
		sel_d.rho = up_data.inv_density;
	end

	assign up_stall = v_s1 & dn_stall;
	assign load     = ~up_stall;
	assign dn_valid = v_s1;
	assign dn_data  = sel_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && up_valid) begin
			sel_s1 <= sel_d;
		end
	end

	`ASSERT_ALWAYS(a_empty_never_stalls, clk, !v_s1 |-> !up_stall, "stage 1 empty but stalling")

endmodule

@@ rtl/upwm_deriv.sv @@
// Stages 2-3: spacing multiply, floor scale and saturation of the derivatives.
`include "assert_macros.svh"
module upwm_deriv (
	input  logic             clk,
	input  logic             arst_n,
	input  upwm_pkg::cfg_t   cfg,
	input  logic             up_valid,
	output logic             up_stall,
	input  upwm_pkg::sel_t   up_data,
	output logic             dn_valid,
	input  logic             dn_stall,
	output upwm_pkg::deriv_t dn_data
);

	localparam int PW = upwm_pkg::PROD_W;
	localparam int VW = upwm_pkg::VAL_W;
	localparam logic signed [PW-1:0] PMAX = {{(PW-VW+1){1'b0}}, {(VW-1){1'b1}}};
	localparam logic signed [PW-1:0] PMIN = {{(PW-VW+1){1'b1}}, {(VW-1){1'b0}}};
	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

	// {clip, value}
	function automatic logic [VW:0] sat(input logic signed [PW-1:0] x);
		logic [VW:0] r;
		if (x > PMAX) begin
			r = {1'b1, VMAX};
		end else if (x < PMIN) begin
			r = {1'b1, VMIN};
		end else begin
			r = {1'b0, x[VW-1:0]};
		end
		return r;
	endfunction

	logic                        v_s2, v_s3;
	logic                        stall_s3;
	logic signed [PW-1:0]        prod_p_s2, prod_x_s2, prod_y_s2, prod_z_s2;
	logic signed [VW-1:0]        vx_s2, vy_s2, vz_s2;
	logic [upwm_pkg::DENS_W-1:0] rho_s2;
	logic [VW:0]                 sp, sx, sy, sz;
	upwm_pkg::deriv_t            d_s3;

	assign stall_s3 = v_s3 & dn_stall;
	assign up_stall = v_s2 & stall_s3;

	// Stage 2: difference times reciprocal spacing, exact.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!up_stall) begin
			v_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			prod_p_s2 <= up_data.diff_p * $signed({1'b0, cfg.inv_dx});
			prod_x_s2 <= up_data.diff_x * $signed({1'b0, cfg.inv_dx});
			prod_y_s2 <= up_data.diff_y * $signed({1'b0, cfg.inv_dy});
			prod_z_s2 <= up_data.diff_z * $signed({1'b0, cfg.inv_dz});
			vx_s2     <= up_data.vx;
			vy_s2     <= up_data.vy;
			vz_s2     <= up_data.vz;
			rho_s2    <= up_data.rho;
		end
	end

	// Stage 3: floor shift (one extra bit halves the central difference), clip.
	assign sp = sat(prod_p_s2 >>> (upwm_pkg::FRAC + 1));
	assign sx = sat(prod_x_s2 >>> upwm_pkg::FRAC);
	assign sy = sat(prod_y_s2 >>> upwm_pkg::FRAC);
	assign sz = sat(prod_z_s2 >>> upwm_pkg::FRAC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (!stall_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s3 && v_s2) begin
			d_s3.dp       <= $signed(sp[VW-1:0]);
			d_s3.ddx      <= $signed(sx[VW-1:0]);
			d_s3.ddy      <= $signed(sy[VW-1:0]);
			d_s3.ddz      <= $signed(sz[VW-1:0]);
			d_s3.clip_p   <= sp[VW];
			d_s3.clip_adv <= sx[VW] | sy[VW] | sz[VW];
			d_s3.vx       <= vx_s2;
			d_s3.vy       <= vy_s2;
			d_s3.vz       <= vz_s2;
			d_s3.rho      <= rho_s2;
		end
	end

	assign dn_valid = v_s3;
	assign dn_data  = d_s3;

	`ASSERT_RST(a_clip_p_extreme, clk, arst_n, v_s3 && d_s3.clip_p |-> (d_s3.dp == VMAX || d_s3.dp == VMIN), "pressure clip without extreme value")
	`ASSERT_RST(a_s2_holds, clk, arst_n, v_s2 && stall_s3 |=> v_s2 && $stable(prod_x_s2), "stage 2 lost data under stall")

endmodule

@@ rtl/upwm_combine.sv @@
// Stages 4-5: velocity and density products, term sum, final saturation.
`include "assert_macros.svh"
module upwm_combine (
	input  logic             clk,
	input  logic             arst_n,
	input  upwm_pkg::cfg_t   cfg,
	input  logic             up_valid,
	output logic             up_stall,
	input  upwm_pkg::deriv_t up_data,
	output logic             dn_valid,
	input  logic             dn_stall,
	output upwm_pkg::rhs_t   dn_data
);

	localparam int MW = upwm_pkg::MUL_W;
	localparam int SW = upwm_pkg::SUM_W;
	localparam int VW = upwm_pkg::VAL_W;
	localparam logic signed [SW-1:0] SMAX = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = {{(SW-VW+1){1'b1}}, {(VW-1){1'b0}}};

	logic                 v_s4, v_s5;
	logic                 stall_s5;
	logic signed [MW-1:0] mx_s4, my_s4, mz_s4, mp_s4;
	logic                 clip_p_s4, clip_adv_s4;
	logic signed [SW-1:0] ax, ay, az, pterm, adv, total;
	logic signed [VW-1:0] total_sat;
	logic                 clip_fin, sat_flag;
	upwm_pkg::rhs_t       rhs_s5;

	assign stall_s5 = v_s5 & dn_stall;
	assign up_stall = v_s4 & stall_s5;

	// Stage 4: velocity times derivative, density times pressure gradient.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (!up_stall) begin
			v_s4 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			mx_s4       <= up_data.vx * up_data.ddx;
			my_s4       <= up_data.vy * up_data.ddy;
			mz_s4       <= up_data.vz * up_data.ddz;
			mp_s4       <= $signed({1'b0, up_data.rho}) * up_data.dp;
			clip_p_s4   <= up_data.clip_p;
			clip_adv_s4 <= up_data.clip_adv;
		end
	end

	// Stage 5: floor shifts, exact sum, gated terms, clip.
	always_comb begin
		ax    = SW'(mx_s4 >>> upwm_pkg::FRAC);
		ay    = SW'(my_s4 >>> upwm_pkg::FRAC);
		az    = SW'(mz_s4 >>> upwm_pkg::FRAC);
		pterm = SW'(mp_s4 >>> upwm_pkg::FRAC);
		adv   = ax + ay + az;
		total = (cfg.pressure_enable ? -pterm : '0) - (cfg.advection_enable ? adv : '0);
		if (total > SMAX) begin
			total_sat = SMAX[VW-1:0];
			clip_fin  = 1'b1;
		end else if (total < SMIN) begin
			total_sat = SMIN[VW-1:0];
			clip_fin  = 1'b1;
		end else begin
			total_sat = total[VW-1:0];
			clip_fin  = 1'b0;
		end
		sat_flag = clip_fin | (cfg.pressure_enable & clip_p_s4)
		         | (cfg.advection_enable & clip_adv_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (!stall_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s5 && v_s4) begin
			rhs_s5.rhs_value <= upwm_pkg::FIELD_W'(total_sat);
			rhs_s5.saturated <= sat_flag;
		end
	end

	assign dn_valid = v_s5;
	assign dn_data  = rhs_s5;

	`ASSERT_RST(a_s4_advances, clk, arst_n, v_s4 && !v_s5 |=> v_s5, "stage 4 did not advance into empty output")

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the upwind x-momentum right-hand-side pipeline.
`timescale 1ns / 1ps

module testbench;

	// Q16.16 values used by the directed cells and the register plans
	localparam logic [31:0] Q_ONE   = 32'h0001_0000;
	localparam logic [31:0] V_MAX   = 32'h7FFF_FFFF;
	localparam logic [31:0] V_MIN   = 32'h8000_0000;
	localparam logic [31:0] V_NEG1  = 32'hFFFF_FFFF;
	localparam logic [30:0] RHO_MAX = 31'h7FFF_FFFF;
	localparam logic [30:0] RHO_ONE = 31'h0001_0000;

	localparam int PHASES          = 8;
	localparam int CELLS_PER_PHASE = 241;
	localparam int HOLD_AFTER      = 60;	// results taken before the long hold-off
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 12;	// covers the five pipeline stages plus margin
	localparam int CYCLE_LIMIT     = 200000;

	// One queued cell; fixed_want marks a row whose result is written out by hand.
	typedef struct packed {
		upwm_pkg::stencil_t stim;
		logic               fixed_want;
		upwm_pkg::rhs_t     want;
	} cell_job_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_COIN,
		STALL_PERIODIC,
		STALL_SPARSE
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [upwm_pkg::ADDR_W-1:0] paddr = '0;
	logic [upwm_pkg::DATA_W-1:0] pwdata = '0;
	logic [upwm_pkg::DATA_W-1:0] prdata;
	logic        pready;
	logic        stencil_valid = 1'b0;
	logic        stencil_stall;
	upwm_pkg::stencil_t stencil = '0;
	logic        rhs_valid;
	logic        rhs_stall = 1'b0;
	upwm_pkg::rhs_t rhs;

	upwind_momentum_rhs_x u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.stencil_valid (stencil_valid),
		.stencil_stall (stencil_stall),
		.stencil       (stencil),
		.rhs_valid     (rhs_valid),
		.rhs_stall     (rhs_stall),
		.rhs           (rhs)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bench copy of the register file, mirrored on every write.
	upwm_pkg::cfg_t cfg_now = {Q_ONE, Q_ONE, Q_ONE, 1'b1, 1'b1};

	cell_job_t      cell_q[$];	// cells waiting to be offered
	upwm_pkg::rhs_t rhs_due_q[$];	// results owed by the pipeline, oldest first
	cell_job_t      cur_job;
	upwm_pkg::rhs_t due;
	int        cells_queued = 0;
	int        cells_taken = 0;
	int        burst_left = 0;
	int        gap_left = 0;
	int        errors = 0;
	int        cycle_cnt = 0;
	int        results_seen = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;
	int        mode_left = 0;
	int        rx_tick = 0;
	stall_mode_t stall_mode = STALL_NONE;
	logic      stall_bit;

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// ---------------------------------------------------------------------
	// Predictor: Q16.16 arithmetic on 64-bit integers, VAL_W-bit saturation
	// ---------------------------------------------------------------------

	// Low VAL_W bits of a field, sign-extended.
	function automatic longint to_val(input logic [upwm_pkg::FIELD_W-1:0] f);
		longint t;
		t = longint'(f) << (64 - upwm_pkg::VAL_W);
		return t >>> (64 - upwm_pkg::VAL_W);
	endfunction

	function automatic longint clip_val(input longint x, inout bit hit);
		longint hi_lim;
		longint lo_lim;
		hi_lim = (longint'(1) << (upwm_pkg::VAL_W - 1)) - 1;
		lo_lim = -hi_lim - 1;
		if (x > hi_lim) begin
			hit = 1'b1;
			return hi_lim;
		end
		if (x < lo_lim) begin
			hit = 1'b1;
			return lo_lim;
		end
		return x;
	endfunction

	// floor((hi - lo) * recip / 2^sh), then saturated. The magnitude product
	// can reach 2^64 - 2^33 + 1, so it is formed unsigned.
	function automatic longint scaled_diff(input longint hi, input longint lo,
			input logic [31:0] recip, input int sh, inout bit hit);
		longint    d;
		bit [63:0] mag;
		longint    q;
		d = hi - lo;
		mag = (d < 0) ? -d : d;
		mag = mag * {32'd0, recip};
		if (d >= 0)
			q = longint'(mag >> sh);
		else
			q = -longint'((mag + ((64'd1 << sh) - 64'd1)) >> sh);
		return clip_val(q, hit);
	endfunction

	// Zero velocity counts as non-negative: backward difference.
	function automatic longint upwind_slope(input longint vel, input longint centre,
			input longint prev, input longint next, input logic [31:0] recip,
			inout bit hit);
		if (vel >= 0)
			return scaled_diff(centre, prev, recip, upwm_pkg::FRAC, hit);
		return scaled_diff(next, centre, recip, upwm_pkg::FRAC, hit);
	endfunction

	function automatic upwm_pkg::rhs_t calc_momentum_rhs(input upwm_pkg::stencil_t c,
			input upwm_pkg::cfg_t k);
		longint vx;
		longint vy;
		longint vz;
		longint dp;
		longint ddx;
		longint ddy;
		longint ddz;
		longint acc;
		bit     hit;
		upwm_pkg::rhs_t r;
		hit = 1'b0;
		acc = 0;
		vx = to_val(c.vx_center);
		vy = to_val(c.vy_center);
		vz = to_val(c.vz_center);
		if (k.pressure_enable) begin
			// central difference; the extra shift bit folds in the halving
			dp = scaled_diff(to_val(c.p_x_plus), to_val(c.p_x_minus), k.inv_dx,
				upwm_pkg::FRAC + 1, hit);
			acc -= (longint'(c.inv_density) * dp) >>> upwm_pkg::FRAC;
		end
		if (k.advection_enable) begin
			ddx = upwind_slope(vx, vx, to_val(c.vx_x_minus), to_val(c.vx_x_plus),
				k.inv_dx, hit);
			ddy = upwind_slope(vy, vx, to_val(c.vx_y_minus), to_val(c.vx_y_plus),
				k.inv_dy, hit);
			ddz = upwind_slope(vz, vx, to_val(c.vx_z_minus), to_val(c.vx_z_plus),
				k.inv_dz, hit);
			acc -= ((vx * ddx) >>> upwm_pkg::FRAC) + ((vy * ddy) >>> upwm_pkg::FRAC)
				+ ((vz * ddz) >>> upwm_pkg::FRAC);
		end
		acc = clip_val(acc, hit);
		r.rhs_value = acc[31:0];
		r.saturated = hit;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus builders
	// ---------------------------------------------------------------------

	function automatic cell_job_t mk_row(input bit fixed, input logic [31:0] want_val,
			input bit want_sat, input logic [31:0] vx, vxm, vxp, vym, vyp, vzm, vzp,
			input logic [31:0] vy, vz, pm, pp, input logic [30:0] rho);
		cell_job_t j;
		j.stim = {vx, vxm, vxp, vym, vyp, vzm, vzp, vy, vz, pm, pp, rho};
		j.fixed_want = fixed;
		j.want.rhs_value = want_val;
		j.want.saturated = want_sat;
		return j;
	endfunction

	// Mix of full-range words, values near the useful range, tiny values
	// and the corner values.
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom;
			3, 4, 5, 6: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			7: return $urandom_range(0, 32) - 16;
			default: begin
				case ($urandom_range(0, 5))
					0: return V_MAX;
					1: return V_MIN;
					2: return 32'd0;
					3: return V_NEG1;
					4: return Q_ONE;
					default: return -Q_ONE;
				endcase
			end
		endcase
	endfunction

	// Smooth cells keep neighbours within about one unit of the centre.
	function automatic logic [31:0] neighbour(input logic [31:0] base, input bit smooth);
		if (smooth)
			return base + ($urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
		return rand_word();
	endfunction

	function automatic cell_job_t rand_job();
		cell_job_t j;
		logic [31:0] base;
		bit          smooth;
		base = rand_word();
		smooth = 1'($urandom_range(0, 1));
		j.stim.vx_center  = base;
		j.stim.vx_x_minus = neighbour(base, smooth);
		j.stim.vx_x_plus  = neighbour(base, smooth);
		j.stim.vx_y_minus = neighbour(base, smooth);
		j.stim.vx_y_plus  = neighbour(base, smooth);
		j.stim.vx_z_minus = neighbour(base, smooth);
		j.stim.vx_z_plus  = neighbour(base, smooth);
		j.stim.vy_center  = rand_word();
		j.stim.vz_center  = rand_word();
		j.stim.p_x_minus  = rand_word();
		j.stim.p_x_plus   = neighbour(j.stim.p_x_minus, smooth);
		case ($urandom_range(0, 5))
			0, 1: j.stim.inv_density = 31'($urandom >> 1);
			2, 3: j.stim.inv_density = 31'($urandom_range(0, 32'h0004_0000));
			4: j.stim.inv_density = RHO_MAX;
			default: j.stim.inv_density = '0;
		endcase
		j.fixed_want = 1'b0;
		j.want = '0;
		return j;
	endfunction

	// ---------------------------------------------------------------------
	// Register access: write, then read back the same register
	// ---------------------------------------------------------------------

	task automatic apb_write(input upwm_pkg::reg_idx_t idx, input logic [31:0] data);
		logic [31:0] got;
		logic [31:0] want;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// write lands here; go straight into the setup phase of the read
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			upwm_pkg::REG_INV_DX: cfg_now.inv_dx = data;
			upwm_pkg::REG_INV_DY: cfg_now.inv_dy = data;
			upwm_pkg::REG_INV_DZ: cfg_now.inv_dz = data;
			upwm_pkg::REG_P_EN:   cfg_now.pressure_enable = data[0];
			upwm_pkg::REG_A_EN:   cfg_now.advection_enable = data[0];
			default: ;
		endcase
		case (idx)
			upwm_pkg::REG_P_EN, upwm_pkg::REG_A_EN: want = {31'd0, data[0]};
			default: want = data;
		endcase
		if (got !== want)
			report_mismatch($sformatf("reg %s read back %h, wrote %h", idx.name(),
				got, want));
	endtask

	task automatic program_regs(input upwm_pkg::cfg_t k);
		apb_write(upwm_pkg::REG_INV_DX, k.inv_dx);
		apb_write(upwm_pkg::REG_INV_DY, k.inv_dy);
		apb_write(upwm_pkg::REG_INV_DZ, k.inv_dz);
		apb_write(upwm_pkg::REG_P_EN, {31'd0, k.pressure_enable});
		apb_write(upwm_pkg::REG_A_EN, {31'd0, k.advection_enable});
	endtask

	// Blocks until every queued cell went in and every owed result came out.
	task automatic wait_idle();
		while (cells_taken != cells_queued || rhs_due_q.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Stencil sender and result checker. Results are checked before the
	// expectation of a cell taken on the same edge is queued.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (rhs_valid && !rhs_stall) begin
			if (rhs_due_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h/%b", rhs.rhs_value,
					rhs.saturated));
			end else begin
				due = rhs_due_q.pop_front();
				if (rhs.rhs_value !== due.rhs_value)
					report_mismatch($sformatf("rhs_value got %h want %h",
						rhs.rhs_value, due.rhs_value));
				if (rhs.saturated !== due.saturated)
					report_mismatch($sformatf("saturated got %b want %b (rhs_value %h)",
						rhs.saturated, due.saturated, due.rhs_value));
			end
		end

		// a transaction on the stencil channel: its result is owed now
		if (stencil_valid && !stencil_stall) begin
			rhs_due_q.push_back(cur_job.fixed_want ? cur_job.want
				: calc_momentum_rhs(cur_job.stim, cfg_now));
			cells_taken++;
		end

		// next offer; a stalled cell stays put
		if (!stencil_valid || !stencil_stall) begin
			if (gap_left > 0 || cell_q.size() == 0) begin
				stencil_valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				cur_job = cell_q.pop_front();
				stencil_valid <= 1'b1;
				stencil <= cur_job.stim;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// a third of the bursts run straight into the next one
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result receiver: stall pattern that switches mode every so often, plus
	// one long hold-off that lets the pipeline fill and push back.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		rx_tick++;
		if (rhs_valid && !rhs_stall)
			results_seen++;
		if (!hold_done && results_seen == HOLD_AFTER) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(32, 256);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			STALL_COIN:     stall_bit = 1'($urandom_range(0, 1));
			STALL_PERIODIC: stall_bit = (rx_tick % 5) < 2;
			STALL_SPARSE:   stall_bit = ($urandom_range(0, 7) == 0);
			default:        stall_bit = 1'b0;
		endcase
		rhs_stall <= (hold_left > 0) || stall_bit;
		if (hold_left > 0)
			hold_left--;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		cell_job_t      directed_rows[$];
		upwm_pkg::cfg_t plan[PHASES];

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cells at the reset register values (spacing 1.0, both terms on).
		// Columns: fixed, want value, want sat, vx, vx-x, vx+x, vx-y, vx+y, vx-z,
		// vx+z, vy, vz, p-x, p+x, inv_density.
		// all zero
		directed_rows.push_back(mk_row(1, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// unit x velocity with a unit backward slope: -1.0
		directed_rows.push_back(mk_row(1, 32'hFFFF_0000, 0, Q_ONE, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 0));
		// pressure step of 2.0 over two cells at unit inverse density: -1.0
		directed_rows.push_back(mk_row(1, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 32'h0002_0000, RHO_ONE));
		// extreme x slopes, both signs of vx: derivative and sum clip
		directed_rows.push_back(mk_row(1, V_MIN, 1, V_MAX, V_MIN, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(1, V_MAX, 1, V_MIN, 0, V_MAX, 0, 0, 0, 0,
			0, 0, 0, 0, 0));
		// widest pressure jump at largest inverse density
		directed_rows.push_back(mk_row(1, V_MIN, 1, 0, 0, 0, 0, 0, 0, 0,
			0, 0, V_MIN, V_MAX, RHO_MAX));
		// clipped slope multiplied by zero velocity still raises the flag
		directed_rows.push_back(mk_row(1, 32'h0, 1, 0, V_MIN, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 0));
		// all ones
		directed_rows.push_back(mk_row(0, 0, 0, V_NEG1, V_NEG1, V_NEG1, V_NEG1, V_NEG1,
			V_NEG1, V_NEG1, V_NEG1, V_NEG1, V_NEG1, V_NEG1, RHO_MAX));
		// y upwinding: zero, negative and positive vy over the same neighbours
		directed_rows.push_back(mk_row(0, 0, 0, Q_ONE, 0, 0, 32'h0003_0000, 32'hFFFB_0000,
			0, 0, 32'h0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(0, 0, 0, Q_ONE, 0, 0, 32'h0003_0000, 32'hFFFB_0000,
			0, 0, 32'hFFFF_8000, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(0, 0, 0, Q_ONE, 0, 0, 32'h0003_0000, 32'hFFFB_0000,
			0, 0, 32'h0000_8000, 0, 0, 0, 0));
		// z upwinding, negative then positive vz
		directed_rows.push_back(mk_row(0, 0, 0, Q_ONE, 0, 0, 0, 0, 32'h0002_0000,
			32'hFFFE_0000, 0, 32'hFFFF_C000, 0, 0, 0));
		directed_rows.push_back(mk_row(0, 0, 0, Q_ONE, 0, 0, 0, 0, 32'h0002_0000,
			32'hFFFE_0000, 0, 32'h0000_4000, 0, 0, 0));
		// floor rounding of negative one-LSB quantities
		directed_rows.push_back(mk_row(0, 0, 0, V_NEG1, 0, 0, 0, 0, 0, 0,
			0, 0, 32'h1, 32'h0, RHO_ONE));
		// negative vx takes the forward x difference
		directed_rows.push_back(mk_row(0, 0, 0, 32'hFFFE_0000, 32'h0005_0000, 32'hFFFC_8000,
			0, 0, 0, 0, 0, 0, 0, 0, 0));
		// alternating bit patterns and their complements
		directed_rows.push_back(mk_row(0, 0, 0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA));
		directed_rows.push_back(mk_row(0, 0, 0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555));
		// every field at its top, then at its bottom
		directed_rows.push_back(mk_row(0, 0, 0, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX,
			V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, RHO_MAX));
		directed_rows.push_back(mk_row(0, 0, 0, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN,
			V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, 0));

		foreach (directed_rows[i]) begin
			cell_q.push_back(directed_rows[i]);
			cells_queued++;
		end
		wait_idle();

		// Register plans, one per random phase: unit spacing (also carries the long
		// hold-off), both spacing extremes, mixed fixed values, each term alone, both
		// terms off, both on at random spacings, then fully random settings.
		plan[0] = {Q_ONE, Q_ONE, Q_ONE, 1'b1, 1'b1};
		plan[1] = {32'h0, 32'h0, 32'h0, 1'b1, 1'b1};
		plan[2] = {V_NEG1, V_NEG1, V_NEG1, 1'b1, 1'b1};
		plan[3] = {32'h0002_0000, 32'h0000_8000, 32'h0004_0000, 1'b1, 1'b0};
		plan[4] = {32'($urandom_range(0, 32'h0008_0000)), 32'($urandom_range(0, 32'h0008_0000)),
			32'($urandom_range(0, 32'h0008_0000)), 1'b0, 1'b1};
		plan[5] = {32'($urandom), 32'($urandom), 32'($urandom), 1'b0, 1'b0};
		plan[6] = {32'($urandom_range(0, 32'h0008_0000)), 32'($urandom_range(0, 32'h0008_0000)),
			32'($urandom_range(0, 32'h0008_0000)), 1'b1, 1'b1};
		plan[7] = {32'($urandom), 32'($urandom), 32'($urandom),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))};

		for (int p = 0; p < PHASES; p++) begin
			program_regs(plan[p]);
			for (int n = 0; n < CELLS_PER_PHASE; n++) begin
				cell_q.push_back(rand_job());
				cells_queued++;
			end
			wait_idle();
		end

		// let any stray result show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
